// ===== rtl/compacting_array_table_assert.svh =====
// Assertion macros shared by the compacting array table RTL.
`ifndef COMPACTING_ARRAY_TABLE_ASSERT_SVH
`define COMPACTING_ARRAY_TABLE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define CAT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define CAT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cat_pkg.sv =====
// Package with the types, codes and defaults of the compacting array table.
package cat_pkg;

	// Default sizing of the table.
	localparam int DEPTH_DEF      = 256;
	localparam int DATA_WIDTH_DEF = 32;

	// Fixed widths of the word fields.
	localparam int ACTION_W = 3;
	localparam int POS_W    = 8;
	localparam int WDATA_W  = 32;
	localparam int RDATA_W  = 32;
	localparam int COUNT_W  = 9;

	// Action codes; the two remaining codes are rejected.
	localparam logic [ACTION_W-1:0] ACT_READ      = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_WRITE     = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_REMOVE    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_APPEND    = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_POP_END   = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_POP_FRONT = 3'd5;

	// Controller states.
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_WORK
	} state_t;

	// Command word.
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [POS_W-1:0]    position;
		logic [WDATA_W-1:0]  write_data;
	} req_t;

	// Result word.
	typedef struct packed {
		logic [RDATA_W-1:0] read_data;
		logic               status;
		logic [COUNT_W-1:0] count;
	} rsp_t;

endpackage

// ===== rtl/cat_ram.sv =====
// Simple dual-port entry memory with one write port and one registered read port.
module cat_ram #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 32,
	localparam int AW        = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [DATA_WIDTH-1:0] wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [DATA_WIDTH-1:0] rdata
);

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; rdata is registered and shows the addressed entry in the cycle after re.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/compacting_array_table.sv =====
// Top level of the compacting array table: controller, entry count and entry memory.
// A fixed-capacity table kept compact: entries 0 to count-1 are valid. A command word is
// taken when start is high and busy is low, and each command gives exactly one result word,
// shown on rsp for a single cycle with done high; the receiver cannot hold it off. Write and
// append and every rejected command finish without raising busy, and their result appears
// in the cycle after the command is taken. Read, pop end and pop front of the last entry keep
// busy high while the entry is read and registered, then give the result. Remove at position p
// (and pop front) moves every later entry down one place through the single memory read port
// and write port, one entry per cycle, and then gives its result. There is no
// clearing pass after reset: the memory holds no reset value and only written entries are read.
`include "compacting_array_table_assert.svh"

module compacting_array_table import cat_pkg::*; #(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int XW   = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int MAXW = (DATA_WIDTH > WDATA_W) ? DATA_WIDTH : WDATA_W;

	localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

	// Control registers.
	state_t         state_q, state_nxt;
	logic [CW-1:0]  cnt_q, cnt_nxt;
	logic           done_q, done_nxt;
	logic           rd_pend_s1, rd_pend_nxt;

	// Working registers of a read or a shift.
	logic                  rd_first_s1, rd_first_nxt;
	logic [AW-1:0]         rd_addr_s1, rd_addr_nxt;
	logic [CW-1:0]         j_q, j_nxt;
	logic                  dec_q, dec_nxt;
	logic [DATA_WIDTH-1:0] data_q, data_nxt;
	rsp_t                  rsp_q, rsp_nxt;

	// Memory port signals.
	logic                  mem_we, mem_re;
	logic [AW-1:0]         mem_waddr, mem_raddr;
	logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

	// Widened views for compares and data width changes.
	logic            accept;
	logic [XW-1:0]   pos_x, cnt_x, pos_inc_x, fin_cnt_x;
	logic [MAXW-1:0] wd_ext, rd_ext;

	assign accept    = start && (state_q == ST_IDLE);
	assign pos_x     = XW'(req.position);
	assign cnt_x     = XW'(cnt_q);
	assign pos_inc_x = pos_x + XW'(1);
	assign fin_cnt_x = XW'(cnt_q - CW'(dec_q));
	assign wd_ext    = MAXW'(req.write_data);
	assign rd_ext    = MAXW'(data_q);

	cat_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// State and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			done_q     <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_nxt;
			cnt_q      <= cnt_nxt;
			done_q     <= done_nxt;
			rd_pend_s1 <= rd_pend_nxt;
		end
	end

	// Working and result registers.
	always_ff @(posedge clk) begin
		rd_first_s1 <= rd_first_nxt;
		rd_addr_s1  <= rd_addr_nxt;
		j_q         <= j_nxt;
		dec_q       <= dec_nxt;
		data_q      <= data_nxt;
		rsp_q       <= rsp_nxt;
	end

	// Command decode, shift sequencing and result formation.
	always_comb begin
		state_nxt    = state_q;
		cnt_nxt      = cnt_q;
		done_nxt     = 1'b0;
		rd_pend_nxt  = rd_pend_s1;
		rd_first_nxt = rd_first_s1;
		rd_addr_nxt  = rd_addr_s1;
		j_nxt        = j_q;
		dec_nxt      = dec_q;
		data_nxt     = data_q;
		rsp_nxt      = rsp_q;
		mem_we       = 1'b0;
		mem_waddr    = '0;
		mem_wdata    = wd_ext[DATA_WIDTH-1:0];
		mem_re       = 1'b0;
		mem_raddr    = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					// Defaults for a command that finishes at once with an error.
					done_nxt          = 1'b1;
					rsp_nxt.read_data = '0;
					rsp_nxt.status    = 1'b1;
					rsp_nxt.count     = cnt_x[COUNT_W-1:0];
					unique case (req.action)
						ACT_READ: begin
							if (pos_x < cnt_x) begin
								mem_re       = 1'b1;
								mem_raddr    = pos_x[AW-1:0];
								rd_addr_nxt  = pos_x[AW-1:0];
								j_nxt        = cnt_q;
								dec_nxt      = 1'b0;
								rd_pend_nxt  = 1'b1;
								rd_first_nxt = 1'b1;
								done_nxt     = 1'b0;
								state_nxt    = ST_WORK;
							end
						end
						ACT_WRITE: begin
							if (pos_x < cnt_x) begin
								mem_we         = 1'b1;
								mem_waddr      = pos_x[AW-1:0];
								rsp_nxt.status = 1'b0;
							end else if (pos_x == cnt_x && cnt_x < DEPTH_X) begin
								mem_we         = 1'b1;
								mem_waddr      = pos_x[AW-1:0];
								cnt_nxt        = cnt_q + CW'(1);
								rsp_nxt.status = 1'b0;
								rsp_nxt.count  = COUNT_W'(cnt_x + XW'(1));
							end
						end
						ACT_REMOVE: begin
							if (pos_x < cnt_x) begin
								mem_re       = 1'b1;
								mem_raddr    = pos_x[AW-1:0];
								rd_addr_nxt  = pos_x[AW-1:0];
								j_nxt        = pos_inc_x[CW-1:0];
								dec_nxt      = 1'b1;
								rd_pend_nxt  = 1'b1;
								rd_first_nxt = 1'b1;
								done_nxt     = 1'b0;
								state_nxt    = ST_WORK;
							end
						end
						ACT_APPEND: begin
							if (cnt_x < DEPTH_X) begin
								mem_we         = 1'b1;
								mem_waddr      = cnt_x[AW-1:0];
								cnt_nxt        = cnt_q + CW'(1);
								rsp_nxt.status = 1'b0;
								rsp_nxt.count  = COUNT_W'(cnt_x + XW'(1));
							end
						end
						ACT_POP_END: begin
							if (cnt_q != '0) begin
								mem_re       = 1'b1;
								mem_raddr    = AW'(cnt_x - XW'(1));
								rd_addr_nxt  = AW'(cnt_x - XW'(1));
								j_nxt        = cnt_q;
								dec_nxt      = 1'b1;
								rd_pend_nxt  = 1'b1;
								rd_first_nxt = 1'b1;
								done_nxt     = 1'b0;
								state_nxt    = ST_WORK;
							end
						end
						ACT_POP_FRONT: begin
							if (cnt_q != '0) begin
								mem_re       = 1'b1;
								mem_raddr    = '0;
								rd_addr_nxt  = '0;
								j_nxt        = CW'(1);
								dec_nxt      = 1'b1;
								rd_pend_nxt  = 1'b1;
								rd_first_nxt = 1'b1;
								done_nxt     = 1'b0;
								state_nxt    = ST_WORK;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_WORK: begin
				if (rd_pend_s1) begin
					// The first read returns the entry; later reads move down one place.
					if (rd_first_s1) begin
						data_nxt = mem_rdata;
					end else begin
						mem_we    = 1'b1;
						mem_waddr = rd_addr_s1 - AW'(1);
						mem_wdata = mem_rdata;
					end
					// Reads run strictly ahead of writes, so no entry is touched twice at once.
					if (j_q < cnt_q) begin
						mem_re       = 1'b1;
						mem_raddr    = j_q[AW-1:0];
						rd_addr_nxt  = j_q[AW-1:0];
						j_nxt        = j_q + CW'(1);
						rd_pend_nxt  = 1'b1;
						rd_first_nxt = 1'b0;
					end else begin
						rd_pend_nxt = 1'b0;
					end
				end else begin
					// Pipeline drained: publish the entry and the new count.
					cnt_nxt           = cnt_q - CW'(dec_q);
					done_nxt          = 1'b1;
					rsp_nxt.read_data = rd_ext[RDATA_W-1:0];
					rsp_nxt.status    = 1'b0;
					rsp_nxt.count     = fin_cnt_x[COUNT_W-1:0];
					state_nxt         = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// The entry count never exceeds the capacity.
	`CAT_ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH), "count above capacity")
	// A rejected command reports no data.
	`CAT_ASSERT_IMPL(a_err_zero, clk, arst_n, done_q && rsp_q.status, rsp_q.read_data == '0,
		"error result carries data")
	// A drained work pipeline gives its result in the next cycle.
	`CAT_ASSERT_NEXT(a_work_done, clk, arst_n, state_q == ST_WORK && !rd_pend_s1,
		done_q && state_q == ST_IDLE, "work finished without a result")
	// The count changes only together with a result.
	`CAT_ASSERT_IMPL(a_cnt_with_rsp, clk, arst_n, cnt_q != $past(cnt_q), done_q,
		"count changed without a result")

endmodule
